// ===== design/pidd_pkg.sv =====
package pidd_pkg;

    localparam int CONTROL_FREQ_DEF = 16;

    localparam int GAIN_W  = 16;
    localparam int POS_W   = 24;
    localparam int ERR_W   = POS_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DD_W    = DIFF_W + 1;
    localparam int INTEG_W = 40;
    localparam int VEL_W   = 32;

    // Product widths of the gain multiplies.
    localparam int PE_W  = GAIN_W + ERR_W;
    localparam int PD_W  = GAIN_W + DIFF_W;
    localparam int PDD_W = GAIN_W + DD_W;
    localparam int PI_W  = GAIN_W + INTEG_W;

    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [DD_W-1:0]    dd_t;
    typedef logic signed [INTEG_W-1:0] integ_t;
    typedef logic signed [VEL_W-1:0]   vel_t;
    typedef logic signed [PE_W-1:0]    pe_t;
    typedef logic signed [PD_W-1:0]    pd_t;
    typedef logic signed [PDD_W-1:0]   pdd_t;
    typedef logic signed [PI_W-1:0]    pi_t;

    typedef enum logic {
        CMD_STEP  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_GAIN_P  = 2'd0,
        REG_GAIN_I  = 2'd1,
        REG_GAIN_D  = 2'd2,
        REG_GAIN_D2 = 2'd3
    } cfg_index_t;

endpackage

// ===== design/pidd_if.sv =====
interface pidd_pos_if;
    import pidd_pkg::*;

    logic valid;
    logic ready;
    cmd_t command;
    pos_t ref_x;
    pos_t ref_y;
    pos_t now_x;
    pos_t now_y;

    modport source (output valid, command, ref_x, ref_y, now_x, now_y, input ready);
    modport sink   (input valid, command, ref_x, ref_y, now_x, now_y, output ready);
endinterface

interface pidd_vel_if;
    import pidd_pkg::*;

    logic valid;
    logic ready;
    vel_t vel_x;
    vel_t vel_y;

    modport source (output valid, vel_x, vel_y, input ready);
    modport sink   (input valid, vel_x, vel_y, output ready);
endinterface

interface pidd_cfg_if;
    import pidd_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    gain_t      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pidd_position_to_velocity_core.sv =====
// Channel  Role  Payload                                  Request
// -------  ----  ---------------------------------------  ------------------------
// cfg      sink  index, data                              one gain register write
// pos      sink  command, ref_x, ref_y, now_x, now_y      one step or one clear
// vel      src   vel_x, vel_y                             one velocity command
//
// One request is taken per cycle while pos.ready is high; a step request passes
// through an input register and five pipeline stages before its result shows.
// The stored errors and integral are updated as a request leaves the input
// register, so the feedback path is one 40-bit add and clamp.
// A clear request leaves the input register without waiting on stage 1 and gives no result.
// Each stage holds its item only while the next one is full and stalled, so a
// stall on vel fills the empty stages before pos.ready drops.
// Reset clears the gains, the controller state and all valid flags.
// CONTROL_FREQ must be a power of two.
module pidd_position_to_velocity_core #(
    parameter int CONTROL_FREQ = pidd_pkg::CONTROL_FREQ_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pidd_cfg_if.sink    cfg,
    pidd_pos_if.sink    pos,
    pidd_vel_if.source  vel
);
    import pidd_pkg::*;

    localparam int FREQ_SHIFT = $clog2(CONTROL_FREQ);
    localparam int TOP_W      = PDD_W + 3 * FREQ_SHIFT;
    localparam int SUM_W      = ((TOP_W > PI_W) ? TOP_W : PI_W) + 2;
    localparam int PAIR_W     = SUM_W - 1;
    localparam int TOT_W      = SUM_W + 3;

    typedef logic signed [PAIR_W-1:0]  pair_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [TOT_W-1:0]   tot_t;
    typedef logic signed [INTEG_W:0]   isum_t;

    localparam tot_t   VEL_MAX   = tot_t'({1'b0, {(VEL_W - 1){1'b1}}});
    localparam tot_t   VEL_MIN   = ~VEL_MAX;
    localparam tot_t   LOW_MASK  = tot_t'((64'd1 << FREQ_SHIFT) - 64'd1);
    localparam integ_t INTEG_MAX = integ_t'({1'b0, {(INTEG_W - 1){1'b1}}});
    localparam integ_t INTEG_MIN = ~INTEG_MAX;

    // Gain registers
    gain_t gain_p_reg, gain_i_reg, gain_d_reg, gain_d2_reg;

    // Controller state, one entry per axis (0 east, 1 north)
    integ_t integ_reg [2];
    err_t   perr_reg  [2];
    diff_t  pdiff_reg [2];

    // Stage valid flags
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic s0_is_clear, s0_leave, pos_fire, s1_load;

    // Pipeline payload
    cmd_t   s0_cmd_reg;
    pos_t   s0_ref_reg   [2];
    pos_t   s0_now_reg   [2];
    err_t   s1_err_reg   [2];
    diff_t  s1_diff_reg  [2];
    dd_t    s1_dd_reg    [2];
    integ_t s1_integ_reg [2];
    pe_t    s2_pe_reg    [2];
    pd_t    s2_pd_reg    [2];
    pdd_t   s2_pdd_reg   [2];
    pi_t    s2_pi_reg    [2];
    pair_t  s3_pa_reg    [2];
    pair_t  s3_pb_reg    [2];
    sum_t   s4_sum_reg   [2];
    vel_t   s5_vel_reg   [2];

    err_t   err_next   [2];
    diff_t  diff_next  [2];
    dd_t    dd_next    [2];
    integ_t integ_next [2];
    isum_t  isum       [2];
    pe_t    pe_next    [2];
    pd_t    pd_next    [2];
    pdd_t   pdd_next   [2];
    pi_t    pi_next    [2];
    pair_t  pa_next    [2];
    pair_t  pb_next    [2];
    sum_t   sum_next   [2];
    tot_t   tot        [2];
    tot_t   quo        [2];
    tot_t   quo_adj    [2];
    vel_t   vel_next   [2];

    // Configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            gain_d2_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_GAIN_P:  gain_p_reg  <= cfg.data;
                REG_GAIN_I:  gain_i_reg  <= cfg.data;
                REG_GAIN_D:  gain_d_reg  <= cfg.data;
                REG_GAIN_D2: gain_d2_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    // Handshake and stage control
    assign rdy5 = !v5_reg || vel.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    // A clear request needs no room downstream.
    assign s0_is_clear = (s0_cmd_reg == CMD_CLEAR);
    assign s0_leave    = v0_reg && (s0_is_clear || rdy1);
    assign s1_load     = rdy1 && v0_reg && !s0_is_clear;
    assign pos.ready   = !v0_reg || s0_leave;
    assign pos_fire    = pos.valid && pos.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (pos.ready)
            begin
                v0_reg <= pos.valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg && !s0_is_clear;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage 1: errors, differences and the running integral
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            err_next[a]  = err_t'(s0_ref_reg[a]) - err_t'(s0_now_reg[a]);
            diff_next[a] = diff_t'(err_next[a]) - diff_t'(perr_reg[a]);
            dd_next[a]   = dd_t'(diff_next[a]) - dd_t'(pdiff_reg[a]);
            isum[a]      = isum_t'(integ_reg[a]) + isum_t'(err_next[a]);
            if (gain_i_reg == '0)
            begin
                integ_next[a] = '0;
            end
            else if (isum[a][INTEG_W] != isum[a][INTEG_W-1])
            begin
                integ_next[a] = isum[a][INTEG_W] ? INTEG_MIN : INTEG_MAX;
            end
            else
            begin
                integ_next[a] = isum[a][INTEG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                integ_reg[a] <= '0;
                perr_reg[a]  <= '0;
                pdiff_reg[a] <= '0;
            end
        end
        else if (s0_leave)
        begin
            for (int a = 0; a < 2; a++)
            begin
                if (s0_is_clear)
                begin
                    integ_reg[a] <= '0;
                    perr_reg[a]  <= '0;
                    pdiff_reg[a] <= '0;
                end
                else
                begin
                    integ_reg[a] <= integ_next[a];
                    perr_reg[a]  <= err_next[a];
                    pdiff_reg[a] <= diff_next[a];
                end
            end
        end
    end

    // Stage 2: gain products
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            pe_next[a]  = pe_t'(gain_p_reg) * pe_t'(s1_err_reg[a]);
            pd_next[a]  = pd_t'(gain_d_reg) * pd_t'(s1_diff_reg[a]);
            pdd_next[a] = pdd_t'(gain_d2_reg) * pdd_t'(s1_dd_reg[a]);
            pi_next[a]  = pi_t'(gain_i_reg) * pi_t'(s1_integ_reg[a]);
        end
    end

    // Stages 3 and 4: everything scaled by the frequency so that the integral
    // term needs no division, then summed.
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            pa_next[a]  = (pair_t'(s2_pe_reg[a]) <<< FREQ_SHIFT)
                        + (pair_t'(s2_pd_reg[a]) <<< (2 * FREQ_SHIFT));
            pb_next[a]  = (pair_t'(s2_pdd_reg[a]) <<< (3 * FREQ_SHIFT))
                        + pair_t'(s2_pi_reg[a]);
            sum_next[a] = sum_t'(s3_pa_reg[a]) + sum_t'(s3_pb_reg[a]);
        end
    end

    // Stage 5: times 8, divide by the frequency rounding toward zero, saturate.
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            tot[a] = tot_t'({s4_sum_reg[a], 3'b000});
            quo[a] = tot[a] >>> FREQ_SHIFT;
            if (tot[a][TOT_W-1] && ((tot[a] & LOW_MASK) != '0))
            begin
                quo_adj[a] = quo[a] + tot_t'(1);
            end
            else
            begin
                quo_adj[a] = quo[a];
            end
            if (quo_adj[a] > VEL_MAX)
            begin
                vel_next[a] = VEL_MAX[VEL_W-1:0];
            end
            else if (quo_adj[a] < VEL_MIN)
            begin
                vel_next[a] = VEL_MIN[VEL_W-1:0];
            end
            else
            begin
                vel_next[a] = quo_adj[a][VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_fire)
        begin
            s0_cmd_reg    <= pos.command;
            s0_ref_reg[0] <= pos.ref_x;
            s0_ref_reg[1] <= pos.ref_y;
            s0_now_reg[0] <= pos.now_x;
            s0_now_reg[1] <= pos.now_y;
        end
        for (int a = 0; a < 2; a++)
        begin
            if (s1_load)
            begin
                s1_err_reg[a]   <= err_next[a];
                s1_diff_reg[a]  <= diff_next[a];
                s1_dd_reg[a]    <= dd_next[a];
                s1_integ_reg[a] <= integ_next[a];
            end
            if (rdy2 && v1_reg)
            begin
                s2_pe_reg[a]  <= pe_next[a];
                s2_pd_reg[a]  <= pd_next[a];
                s2_pdd_reg[a] <= pdd_next[a];
                s2_pi_reg[a]  <= pi_next[a];
            end
            if (rdy3 && v2_reg)
            begin
                s3_pa_reg[a] <= pa_next[a];
                s3_pb_reg[a] <= pb_next[a];
            end
            if (rdy4 && v3_reg)
            begin
                s4_sum_reg[a] <= sum_next[a];
            end
            if (rdy5 && v4_reg)
            begin
                s5_vel_reg[a] <= vel_next[a];
            end
        end
    end

    assign vel.valid = v5_reg;
    assign vel.vel_x = s5_vel_reg[0];
    assign vel.vel_y = s5_vel_reg[1];

`ifndef ASSERT_OFF
    // A clear request leaves all controller state at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_leave && s0_is_clear) |=>
            (integ_reg[0] == '0) && (integ_reg[1] == '0) &&
            (perr_reg[0] == '0) && (perr_reg[1] == '0) &&
            (pdiff_reg[0] == '0) && (pdiff_reg[1] == '0))
        else $error("state not cleared by a clear request");

    // With a zero integral gain the integral stays at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_load && (gain_i_reg == '0)) |=>
            (integ_reg[0] == '0) && (integ_reg[1] == '0))
        else $error("integral kept with zero integral gain");

    // The stored state and the item entering stage 1 agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=>
            (integ_reg[0] == s1_integ_reg[0]) && (integ_reg[1] == s1_integ_reg[1]) &&
            (perr_reg[0] == s1_err_reg[0]) && (perr_reg[1] == s1_err_reg[1]) &&
            (pdiff_reg[0] == s1_diff_reg[0]) && (pdiff_reg[1] == s1_diff_reg[1]))
        else $error("controller state out of step with the pipeline");

    // A step request always reaches stage 1 once it leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_leave && !s0_is_clear) |=> v1_reg)
        else $error("step request lost between input register and stage 1");
`endif

endmodule

// ===== test/pidd_position_to_velocity_core_test.sv =====
`timescale 1ns / 1ps

module pidd_position_to_velocity_core_test;
    import pidd_pkg::*;

    localparam int CYCLE_LIMIT   = 60000;
    localparam int SETTLE_CYCLES = 10;
    localparam int SEGMENT_ITEMS = 120;

    localparam pos_t POS_MAX = 24'sh7FFFFF;
    localparam pos_t POS_MIN = 24'sh800000;

    typedef struct {
        vel_t x;
        vel_t y;
    } vel_pair_t;

    class velocity_scoreboard;
        gain_t     kp;
        gain_t     ki;
        gain_t     kd;
        gain_t     kd2;
        longint    integ_sum [2];
        longint    last_err  [2];
        longint    last_diff [2];
        vel_pair_t expected_vel [$];
        int        failures;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            kd2 = '0;
            failures = 0;
            clear_history();
        endfunction

        function void clear_history();
            for (int a = 0; a < 2; a++)
            begin
                integ_sum[a] = 0;
                last_err[a]  = 0;
                last_diff[a] = 0;
            end
        endfunction

        function void write_gain(cfg_index_t idx, gain_t value);
            case (idx)
                REG_GAIN_P:  kp  = value;
                REG_GAIN_I:  ki  = value;
                REG_GAIN_D:  kd  = value;
                REG_GAIN_D2: kd2 = value;
                default: ;
            endcase
        endfunction

        function vel_t axis_velocity(int a, pos_t target, pos_t actual);
            longint f;
            longint err;
            longint diff;
            longint diff2;
            longint fixed_terms;
            longint scaled;
            longint integ_hi;
            longint vel_hi;
            f        = longint'(CONTROL_FREQ_DEF);
            integ_hi = (longint'(1) <<< (INTEG_W - 1)) - 1;
            vel_hi   = (longint'(1) <<< (VEL_W - 1)) - 1;
            err   = longint'(target) - longint'(actual);
            diff  = err - last_err[a];
            diff2 = diff - last_diff[a];
            if (ki == 0)
            begin
                integ_sum[a] = 0;
            end
            else
            begin
                integ_sum[a] = integ_sum[a] + err;
                if (integ_sum[a] > integ_hi)
                    integ_sum[a] = integ_hi;
                else if (integ_sum[a] < -integ_hi - 1)
                    integ_sum[a] = -integ_hi - 1;
            end
            fixed_terms = longint'(kp) * err * 8 + longint'(kd) * f * diff * 8
                        + longint'(kd2) * f * f * diff2 * 8;
            // The integral term carries a division by the frequency, so the whole
            // sum is scaled up by it and divided once; division truncates toward zero.
            scaled = (fixed_terms * f + longint'(ki) * integ_sum[a] * 8) / f;
            if (scaled > vel_hi)
                scaled = vel_hi;
            else if (scaled < -vel_hi - 1)
                scaled = -vel_hi - 1;
            last_err[a]  = err;
            last_diff[a] = diff;
            return vel_t'(scaled);
        endfunction

        function void note_request(cmd_t cmd, pos_t rx, pos_t ry, pos_t nx, pos_t ny);
            vel_pair_t v;
            if (cmd == CMD_CLEAR)
            begin
                clear_history();
                return;
            end
            v.x = axis_velocity(0, rx, nx);
            v.y = axis_velocity(1, ry, ny);
            expected_vel.push_back(v);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_result(vel_t vx, vel_t vy);
            vel_pair_t want;
            if (expected_vel.size() == 0)
            begin
                note_failure($sformatf("velocity with no request waiting, x=%0d y=%0d",
                                       vx, vy));
                return;
            end
            want = expected_vel.pop_front();
            if (vx !== want.x)
                note_failure($sformatf("vel_x expected %0d, got %0d", want.x, vx));
            if (vy !== want.y)
                note_failure($sformatf("vel_y expected %0d, got %0d", want.y, vy));
        endfunction

        function int pending();
            return expected_vel.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    pos_t track_x = '0;
    pos_t track_y = '0;

    velocity_scoreboard sb = new();

    pidd_cfg_if cfg_bus ();
    pidd_pos_if pos_bus ();
    pidd_vel_if vel_bus ();

    pidd_position_to_velocity_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .pos   (pos_bus),
        .vel   (vel_bus)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (rst_n)
            vel_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (vel_bus.valid && vel_bus.ready)
                sb.check_result(vel_bus.vel_x, vel_bus.vel_y);
            if (pos_bus.valid && pos_bus.ready)
                sb.note_request(pos_bus.command, pos_bus.ref_x, pos_bus.ref_y,
                                pos_bus.now_x, pos_bus.now_y);
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_gain(cfg_bus.index, cfg_bus.data);
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int spread(int mag);
        return int'($urandom_range(2 * mag)) - mag;
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return gain_t'(spread(32));
            2:       return gain_t'(spread(512));
            default: return gain_t'($urandom);
        endcase
    endfunction

    task automatic send_request(cmd_t cmd, pos_t rx, pos_t ry, pos_t nx, pos_t ny);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            pos_bus.valid <= 1'b0;
        end
        @(negedge clk);
        pos_bus.valid   <= 1'b1;
        pos_bus.command <= cmd;
        pos_bus.ref_x   <= rx;
        pos_bus.ref_y   <= ry;
        pos_bus.now_x   <= nx;
        pos_bus.now_y   <= ny;
        do @(posedge clk); while (!pos_bus.ready);
    endtask

    // A clear request gives no result, so a short hold-off follows the last one.
    task automatic drain();
        @(negedge clk);
        pos_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(cfg_index_t idx, gain_t value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_gains(gain_t p, gain_t i, gain_t d, gain_t d2);
        drain();
        write_gain(REG_GAIN_P, p);
        write_gain(REG_GAIN_I, i);
        write_gain(REG_GAIN_D, d);
        write_gain(REG_GAIN_D2, d2);
    endtask

    // Mostly a slowly moving reference with the current position close behind,
    // so the errors stay small; now and then a jump or fully random fields.
    task automatic send_random();
        cmd_t cmd;
        pos_t rx;
        pos_t ry;
        pos_t nx;
        pos_t ny;
        int   mag;
        cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_STEP;
        if ($urandom_range(99) < 6)
        begin
            rx = pos_t'($urandom);
            ry = pos_t'($urandom);
            nx = pos_t'($urandom);
            ny = pos_t'($urandom);
        end
        else
        begin
            if ($urandom_range(99) < 4)
            begin
                track_x = pos_t'($urandom);
                track_y = pos_t'($urandom);
            end
            track_x = track_x + pos_t'(spread(64));
            track_y = track_y + pos_t'(spread(64));
            mag = 1 << (2 + 4 * $urandom_range(3));
            rx = track_x;
            ry = track_y;
            nx = track_x - pos_t'(spread(mag));
            ny = track_y - pos_t'(spread(mag));
        end
        send_request(cmd, rx, ry, nx, ny);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        pos_bus.valid   = 1'b0;
        pos_bus.command = CMD_STEP;
        pos_bus.ref_x   = '0;
        pos_bus.ref_y   = '0;
        pos_bus.now_x   = '0;
        pos_bus.now_y   = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_GAIN_P;
        cfg_bus.data    = '0;
        vel_bus.ready   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 86;

        // Gains are still zero from reset.
        send_request(CMD_STEP, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
        set_gains(16'sh0100, 16'sh0080, 16'sh0040, 16'sh0010);
        send_request(CMD_STEP, 0, 0, 0, 0);
        send_request(CMD_STEP, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
        send_request(CMD_STEP, POS_MIN, POS_MAX, POS_MAX, POS_MIN);
        send_request(CMD_STEP, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        send_request(CMD_STEP, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
        send_request(CMD_CLEAR, POS_MAX, POS_MIN, 0, 0);
        send_request(CMD_STEP, 1, -1, 0, 0);
        send_request(CMD_STEP, 3, -2, 1, 0);
        send_request(CMD_STEP, -5, 7, 2, -1);
        // Zero integral gain throws the integral away.
        set_gains(16'sh0100, 16'sh0000, 16'sh0040, 16'sh0010);
        send_request(CMD_STEP, 40, -40, 0, 0);
        send_request(CMD_STEP, 80, -80, 0, 0);
        set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_request(CMD_STEP, 1, -1, 0, 0);
        send_request(CMD_STEP, -1, 1, 0, 0);
        send_request(CMD_STEP, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
        send_request(CMD_CLEAR, 0, 0, 0, 0);
        set_gains(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(CMD_STEP, 1, -1, 0, 0);
        send_request(CMD_STEP, POS_MIN, POS_MAX, POS_MAX, POS_MIN);
        send_request(CMD_STEP, POS_MAX, POS_MIN, POS_MIN, POS_MAX);

        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 6 : (p == 1) ? 86 : 0;
            rx_idle_pct = (p == 0) ? 86 : (p == 1) ? 6 : 0;
            for (int s = 0; s < 3; s++)
            begin
                if (p == 0 && s == 0)
                    set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
                else if (p == 1 && s == 0)
                    set_gains(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
                else
                    set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                begin
                    if (s == 1 && n == SEGMENT_ITEMS / 2)
                        drain();
                    send_random();
                end
            end
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== pidd_position_to_velocity_core.f =====
design/pidd_pkg.sv
design/pidd_if.sv
design/pidd_position_to_velocity_core.sv
test/pidd_position_to_velocity_core_test.sv
